FILE: rtl/core/mede_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mede_pkg;

  // Field widths
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BCNT_W    = 2;
  localparam int unsigned MAX_BYTES = 6;
  localparam int unsigned CNT_W     = 3;

  // Stream tokens and message codes
  localparam logic [BYTE_W-1:0] ACTIVE_SENSE = 8'hFE;
  localparam logic [BYTE_W-1:0] DELAY_TOKEN  = 8'hFE;
  localparam logic [BYTE_W-1:0] GAP_MARK     = 8'hFF;
  localparam logic [BYTE_W-1:0] NOTE_ON_LO   = 8'h90;
  localparam logic [BYTE_W-1:0] NOTE_ON_HI   = 8'hA0;

  // Delay limits
  localparam logic [TICK_W-1:0] LONG_GAP    = 32'd16383;
  localparam logic [TICK_W-1:0] FIRST_CLAMP = 32'd10;

  // Header lengths in front of the message bytes
  localparam logic [1:0] HDR_NONE  = 2'd0;
  localparam logic [1:0] HDR_GAP   = 2'd1;
  localparam logic [1:0] HDR_DELAY = 2'd3;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef logic [BYTE_W-1:0] byte_t;

  // One item's encoded bytes, element 0 leaves first
  typedef struct packed {
    byte_t [MAX_BYTES-1:0] bytes;
    logic [CNT_W-1:0]      cnt;
  } burst_t;

endpackage

`default_nettype wire

FILE: rtl/core/mede_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mede_in_if import mede_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TICK_W-1:0] now_tick;
  logic [BYTE_W-1:0] msg_byte0;
  logic [BYTE_W-1:0] msg_byte1;
  logic [BYTE_W-1:0] msg_byte2;
  logic [BCNT_W-1:0] byte_count;
  logic              sysex;

  modport source (
    output valid, operation, now_tick, msg_byte0, msg_byte1, msg_byte2,
           byte_count, sysex,
    input  ready
  );

  modport sink (
    input  valid, operation, now_tick, msg_byte0, msg_byte1, msg_byte2,
           byte_count, sysex,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/mede_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mede_out_if import mede_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (
    output valid, out_byte, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/midi_event_delay_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted item's bytes load the active run register, or the waiting burst
// buffer while a run drains; each byte leaves from the active run. An item has
// 0 to 6 bytes; the waiting buffer lets the next item be taken while the run
// drains, so items with no bytes go at one per cycle while it stays empty.
// Reset (rst, synchronous): clears both buffers, last tick, first flag and the
// recording enable.
module midi_event_delay_encoder_unit import mede_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  mede_in_if.sink     msg,
  mede_out_if.source  rec,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data
);

  logic              recording_enabled;
  logic [TICK_W-1:0] last_tick;
  logic              first_pending;
  burst_t            act;
  burst_t            pend;
  burst_t            act_next;
  burst_t            pend_next;

  logic              msg_fire;
  logic              rec_fire;
  logic              act_free;
  logic [TICK_W-1:0] diff;
  logic [TICK_W-1:0] dly;
  logic              gap;
  logic              long_gap;
  logic              drop;
  logic              note_on;
  logic [1:0]        hdr_len;
  burst_t            fresh;

  assign msg_fire = msg.valid && msg.ready;
  assign rec_fire = rec.valid && rec.ready;

  // Active run is free next cycle if empty or its last byte leaves now
  assign act_free = (act.cnt == '0) || (rec_fire && (act.cnt == CNT_W'(1)));

  // Handshake outputs
  assign msg.ready       = (pend.cnt == '0);
  assign rec.valid       = (act.cnt != '0);
  assign rec.out_byte    = act.bytes[0];
  assign rec.last_of_run = (act.cnt == CNT_W'(1));

  // Encode one item
  always_comb begin
    diff     = msg.now_tick - last_tick;
    gap      = (diff != '0) && !diff[TICK_W-1];
    long_gap = (diff > LONG_GAP) && !first_pending;
    dly      = (first_pending && (diff > FIRST_CLAMP)) ? FIRST_CLAMP : diff;
    drop     = !recording_enabled || (msg.msg_byte0 == ACTIVE_SENSE) || msg.sysex;
    note_on  = (msg.msg_byte0 >= NOTE_ON_LO) && (msg.msg_byte0 < NOTE_ON_HI);

    if (!gap) begin
      hdr_len = HDR_NONE;
    end else if (long_gap) begin
      hdr_len = HDR_GAP;
    end else begin
      hdr_len = HDR_DELAY;
    end

    fresh.bytes = '0;
    case (hdr_len)
      HDR_NONE: begin
        fresh.bytes[0] = msg.msg_byte0;
        fresh.bytes[1] = msg.msg_byte1;
        fresh.bytes[2] = msg.msg_byte2;
      end
      HDR_GAP: begin
        fresh.bytes[0] = GAP_MARK;
        fresh.bytes[1] = msg.msg_byte0;
        fresh.bytes[2] = msg.msg_byte1;
        fresh.bytes[3] = msg.msg_byte2;
      end
      default: begin
        fresh.bytes[0] = DELAY_TOKEN;
        fresh.bytes[1] = {1'b0, dly[6:0]};
        fresh.bytes[2] = {1'b0, dly[13:7]};
        fresh.bytes[3] = msg.msg_byte0;
        fresh.bytes[4] = msg.msg_byte1;
        fresh.bytes[5] = msg.msg_byte2;
      end
    endcase

    // Start items and dropped events give no bytes
    if ((msg.operation == OP_START) || drop) begin
      fresh.cnt = '0;
    end else begin
      fresh.cnt = CNT_W'(hdr_len) + CNT_W'(msg.byte_count);
    end
  end

  // Recording enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      recording_enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      recording_enabled <= cfg_wr_data;
    end
  end

  // Tick latch and first-event flag
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick     <= '0;
      first_pending <= 1'b0;
    end else if (msg_fire) begin
      if (msg.operation == OP_START) begin
        first_pending <= 1'b1;
        last_tick     <= msg.now_tick;
      end else if (!drop) begin
        if (gap) begin
          last_tick <= msg.now_tick;
        end
        if (note_on) begin
          first_pending <= 1'b0;
        end
      end
    end
  end

  // Next active run and waiting burst; later arms take priority
  always_comb begin
    act_next  = act;
    pend_next = pend;
    if (rec_fire) begin
      act_next.bytes = {BYTE_W'(0), act.bytes[MAX_BYTES-1:1]};
      act_next.cnt   = act.cnt - CNT_W'(1);
    end
    if ((pend.cnt != '0) && act_free) begin
      act_next      = pend;
      pend_next.cnt = '0;
    end
    if (msg_fire && (fresh.cnt != '0)) begin
      if (act_free) begin
        act_next = fresh;
      end else begin
        pend_next = fresh;
      end
    end
  end

  // Active run shifter and waiting burst
  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= '0;
      pend <= '0;
    end else begin
      act  <= act_next;
      pend <= pend_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mede_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mede_checker import mede_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              msg_valid,
  input wire logic              msg_ready,
  input wire logic              rec_valid,
  input wire logic              rec_ready,
  input wire logic [BYTE_W-1:0] rec_out_byte,
  input wire logic              rec_last_of_run
);

  // Reset leaves both buffers empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (msg_ready && !rec_valid))
    else $error("buffers not empty after reset");

  // Input only stalls while a run is on the byte port
  a_stall_has_run: assert property (@(posedge clk) disable iff (rst)
    !msg_ready |-> rec_valid)
    else $error("input stalled with no run in progress");

  // A run continues until its last byte
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_ready && !rec_last_of_run) |=> rec_valid)
    else $error("run ended before its last byte");

  // Stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && !rec_ready) |=>
      (rec_valid && $stable(rec_out_byte) && $stable(rec_last_of_run)))
    else $error("stalled output item changed");

endmodule

bind midi_event_delay_encoder_unit mede_checker u_mede_checker (
  .clk             (clk),
  .rst             (rst),
  .msg_valid       (msg.valid),
  .msg_ready       (msg.ready),
  .rec_valid       (rec.valid),
  .rec_ready       (rec.ready),
  .rec_out_byte    (rec.out_byte),
  .rec_last_of_run (rec.last_of_run)
);

`default_nettype wire
